>>> design/mwm_pkg.sv
// mecanum wheel mixer package: shared constants, queue item and series-stage types
// no dependencies; compiled first
`default_nettype none

package mwm_pkg;

    localparam int ANGLE_BITS = 16;
    localparam int PHASE_BITS = 16;
    localparam int OCT_BITS   = 14;

    localparam logic [31:0] PI_Q30  = 32'd3373259426;
    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

    localparam int N_TERMS    = 5;
    localparam int SER_STAGES = 2 + 3 * N_TERMS + 2;

    localparam logic [6:0] DIV_COS [1:N_TERMS] = '{7'd2, 7'd12, 7'd30, 7'd56, 7'd90};
    localparam logic [6:0] DIV_SIN [1:N_TERMS] = '{7'd6, 7'd20, 7'd42, 7'd72, 7'd110};

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } quad_t;

    typedef struct packed {
        logic [OCT_BITS-1:0] oct;
        logic                swap;
        quad_t               quad;
        logic signed [7:0]   speed;
        logic signed [7:0]   rot;
        logic                imm;
    } cls_t;

    typedef struct packed {
        logic [29:0]        x2;
        logic [30:0]        t_c;
        logic [30:0]        t_s;
        logic [30:0]        q_c;
        logic [30:0]        q_s;
        logic signed [31:0] acc_c;
        logic signed [31:0] acc_s;
        cls_t               cls;
    } ser_t;

endpackage

`default_nettype wire

>>> design/mwm_if.sv
// request and result channel interfaces of the mecanum wheel mixer
// no dependencies
`default_nettype none

interface mwm_cmd_if;
    logic               valid;
    logic               ready;
    logic        [15:0] heading_angle;
    logic signed [15:0] drive_speed;
    logic signed [15:0] turn_rate;
    logic               immediate_flag;

    modport source (output valid, heading_angle, drive_speed, turn_rate, immediate_flag,
                    input ready);
    modport sink   (input valid, heading_angle, drive_speed, turn_rate, immediate_flag,
                    output ready);
endinterface

interface mwm_whl_if;
    logic              valid;
    logic              ready;
    logic signed [7:0] front_right_cmd;
    logic signed [7:0] rear_right_cmd;
    logic signed [7:0] front_left_cmd;
    logic signed [7:0] rear_left_cmd;
    logic              immediate_out;

    modport source (output valid, front_right_cmd, rear_right_cmd, front_left_cmd,
                    rear_left_cmd, immediate_out, input ready);
    modport sink   (input valid, front_right_cmd, rear_right_cmd, front_left_cmd,
                    rear_left_cmd, immediate_out, output ready);
endinterface

`default_nettype wire

>>> design/mwm_front.sv
// front end: accepts requests, saturates speed and rotation, reduces the heading
// to an octant argument and quadrant; depends on mwm_pkg and mwm_if
`default_nettype none

module mwm_front (
    mwm_cmd_if.sink      cmd,
    input  wire logic    q_full,
    output logic         push,
    output mwm_pkg::cls_t cls
);
    import mwm_pkg::*;

    logic [PHASE_BITS-1:0] phase;
    logic [PHASE_BITS-1:0] ph_r;
    logic [OCT_BITS-1:0]   frac;
    logic                  swap;

    function automatic logic signed [7:0] sat127(input logic signed [15:0] v);
        logic signed [7:0] r;
        if (v > 16'sd127)
            r = 8'sd127;
        else if (v < -16'sd127)
            r = -8'sd127;
        else
            r = v[7:0];
        return r;
    endfunction

    generate
        if (ANGLE_BITS >= PHASE_BITS)
        begin : g_narrow
            assign phase = PHASE_BITS'(cmd.heading_angle >> (ANGLE_BITS - PHASE_BITS));
        end
        else
        begin : g_wide
            assign phase = PHASE_BITS'({cmd.heading_angle} << (PHASE_BITS - ANGLE_BITS));
        end
    endgenerate

    // right diagonal phase, left one is a quarter turn behind
    assign ph_r = phase + 16'd8192;
    assign frac = ph_r[OCT_BITS-1:0];
    assign swap = frac > 14'd8192;

    assign cmd.ready = !q_full;
    assign push      = cmd.valid && !q_full;

    always_comb
    begin
        cls.oct   = swap ? OCT_BITS'(15'd16384 - {1'b0, frac}) : frac;
        cls.swap  = swap;
        cls.quad  = quad_t'(ph_r[15:14]);
        cls.speed = sat127(cmd.drive_speed);
        cls.rot   = sat127(cmd.turn_rate);
        cls.imm   = cmd.immediate_flag;
    end

endmodule

`default_nettype wire

>>> design/mwm_queue.sv
// short request queue between the front end and the back end
// depends on mwm_pkg
`default_nettype none

module mwm_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire mwm_pkg::cls_t push_data,
    input  wire logic          pop,
    output logic               full,
    output logic               empty,
    output mwm_pkg::cls_t      pop_data
);
    import mwm_pkg::*;

    cls_t               mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_reg;
    logic [FIFO_AW-1:0] wr_next;
    logic [FIFO_AW-1:0] rd_reg;
    logic [FIFO_AW-1:0] rd_next;
    logic [FIFO_AW:0]   cnt_reg;
    logic [FIFO_AW:0]   cnt_next;

    assign full     = cnt_reg == (FIFO_AW+1)'(FIFO_DEPTH);
    assign empty    = cnt_reg == '0;
    assign pop_data = mem_reg[rd_reg];

    always_comb
    begin
        wr_next  = push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (!push && pop)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_data;
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (FIFO_AW+1)'(FIFO_DEPTH))
        else $error("queue count beyond depth");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> cnt_reg != '0)
        else $error("pop from empty queue");

    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("queue count did not follow push");

endmodule

`default_nettype wire

>>> design/mwm_series.sv
// back end, part one: pipelined Taylor series for cosine and sine of the octant
// argument in Q2.30, rounded to Q1.15; depends on mwm_pkg
`default_nettype none

module mwm_series (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire mwm_pkg::cls_t in_cls,
    output logic               out_valid,
    output logic [15:0]        cos_q,
    output logic [15:0]        sin_q,
    output mwm_pkg::cls_t      out_cls
);
    import mwm_pkg::*;

    ser_t                  stg_reg  [SER_STAGES];
    ser_t                  stg_next [SER_STAGES];
    logic [SER_STAGES-1:0] vld_reg;
    logic [SER_STAGES-1:0] vld_next;

    genvar s;
    generate
        for (s = 0; s < SER_STAGES; s++)
        begin : g_stg
            if (s == 0)
            begin : g_arg
                logic [45:0] xp;
                assign xp = 46'(in_cls.oct) * 46'(PI_Q30);
                always_comb
                begin
                    stg_next[s]     = '0;
                    stg_next[s].cls = in_cls;
                    stg_next[s].t_c = ONE_Q30;
                    stg_next[s].t_s = xp[45:15];
                end
            end
            else if (s == 1)
            begin : g_sq
                logic [59:0] sq;
                assign sq = 60'(stg_reg[s-1].t_s[29:0]) * 60'(stg_reg[s-1].t_s[29:0]);
                always_comb
                begin
                    stg_next[s]    = stg_reg[s-1];
                    stg_next[s].x2 = sq[59:30];
                end
            end
            else if (s < SER_STAGES - 2)
            begin : g_term
                localparam int         K    = (s - 2) / 3 + 1;
                localparam int         PH   = (s - 2) % 3;
                localparam logic [6:0] DC   = DIV_COS[K];
                localparam logic [6:0] DS   = DIV_SIN[K];
                localparam logic [63:0] RC  = (64'd1 << 32) / 64'(DC);
                localparam logic [63:0] RS  = (64'd1 << 32) / 64'(DS);
                localparam bit         ADD  = ((K - 1) % 2) == 0;
                logic [62:0] pc;
                logic [62:0] ps;
                logic [30:0] rem_c;
                logic [30:0] rem_s;

                always_comb
                begin
                    stg_next[s] = stg_reg[s-1];
                    pc    = '0;
                    ps    = '0;
                    rem_c = '0;
                    rem_s = '0;
                    if (PH == 0)
                    begin
                        // next power term, previous term folded into the sums
                        pc = 63'(stg_reg[s-1].t_c) * 63'(stg_reg[s-1].x2);
                        ps = 63'(stg_reg[s-1].t_s) * 63'(stg_reg[s-1].x2);
                        stg_next[s].t_c = pc[60:30];
                        stg_next[s].t_s = ps[60:30];
                        if (ADD)
                        begin
                            stg_next[s].acc_c = stg_reg[s-1].acc_c + $signed({1'b0, stg_reg[s-1].t_c});
                            stg_next[s].acc_s = stg_reg[s-1].acc_s + $signed({1'b0, stg_reg[s-1].t_s});
                        end
                        else
                        begin
                            stg_next[s].acc_c = stg_reg[s-1].acc_c - $signed({1'b0, stg_reg[s-1].t_c});
                            stg_next[s].acc_s = stg_reg[s-1].acc_s - $signed({1'b0, stg_reg[s-1].t_s});
                        end
                    end
                    else if (PH == 1)
                    begin
                        // reciprocal estimate, low by at most one
                        pc = 63'(stg_reg[s-1].t_c) * 63'(RC[31:0]);
                        ps = 63'(stg_reg[s-1].t_s) * 63'(RS[31:0]);
                        stg_next[s].q_c = pc[62:32];
                        stg_next[s].q_s = ps[62:32];
                    end
                    else
                    begin
                        rem_c = stg_reg[s-1].t_c - 31'(stg_reg[s-1].q_c * 31'(DC));
                        rem_s = stg_reg[s-1].t_s - 31'(stg_reg[s-1].q_s * 31'(DS));
                        stg_next[s].t_c = stg_reg[s-1].q_c + 31'(rem_c >= 31'(DC));
                        stg_next[s].t_s = stg_reg[s-1].q_s + 31'(rem_s >= 31'(DS));
                    end
                end
            end
            else if (s == SER_STAGES - 2)
            begin : g_last
                always_comb
                begin
                    stg_next[s]       = stg_reg[s-1];
                    stg_next[s].acc_c = stg_reg[s-1].acc_c - $signed({1'b0, stg_reg[s-1].t_c});
                    stg_next[s].acc_s = stg_reg[s-1].acc_s - $signed({1'b0, stg_reg[s-1].t_s});
                end
            end
            else
            begin : g_round
                logic signed [31:0] rc;
                logic signed [31:0] rs;
                assign rc = stg_reg[s-1].acc_c + 32'sd16384;
                assign rs = stg_reg[s-1].acc_s + 32'sd16384;
                always_comb
                begin
                    stg_next[s]     = stg_reg[s-1];
                    stg_next[s].t_c = stg_reg[s-1].acc_c < 0 ? '0 : 31'(rc[31:15]);
                    stg_next[s].t_s = stg_reg[s-1].acc_s < 0 ? '0 : 31'(rs[31:15]);
                end
            end
        end
    endgenerate

    assign vld_next = {vld_reg[SER_STAGES-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < SER_STAGES; i++)
                stg_reg[i] <= stg_next[i];
        end
    end

    assign out_valid = vld_reg[SER_STAGES-1];
    assign cos_q     = stg_reg[SER_STAGES-1].t_c[15:0];
    assign sin_q     = stg_reg[SER_STAGES-1].t_s[15:0];
    assign out_cls   = stg_reg[SER_STAGES-1].cls;

endmodule

`default_nettype wire

>>> design/mwm_mixer.sv
// back end, part two: quadrant fold, diagonals, wheel mix, overload scaling by a
// pipelined restoring divider, output register; depends on mwm_pkg and mwm_if
`default_nettype none

module mwm_mixer (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire logic [15:0]   cos_q,
    input  wire logic [15:0]   sin_q,
    input  wire mwm_pkg::cls_t cls,
    mwm_whl_if.source          res
);
    import mwm_pkg::*;

    localparam int NST = 6;

    logic [NST-1:0]     vld_reg;
    logic [15:0]        cf;
    logic [15:0]        sf;
    logic signed [16:0] cr;
    logic signed [16:0] cl;

    logic signed [24:0] pr_reg;
    logic signed [24:0] pl_reg;
    logic signed [24:0] pr_next;
    logic signed [24:0] pl_next;
    logic signed [7:0]  rot_reg;
    logic [NST-1:0]     imm_reg;

    logic signed [24:0] tr;
    logic signed [24:0] tl;
    logic signed [8:0]  dr;
    logic signed [8:0]  dl;
    logic signed [8:0]  whl_reg  [4];
    logic signed [8:0]  whl_next [4];

    logic [7:0]  mag [4];
    logic [7:0]  m01;
    logic [7:0]  m23;
    logic [7:0]  mall;
    logic [7:0]  mx2_reg;
    logic [7:0]  mx2_next;
    logic [14:0] num_reg  [4];
    logic [14:0] num_next [4];
    logic [3:0]  neg2_reg;

    logic [14:0] rem3_reg  [4];
    logic [14:0] rem3_next [4];
    logic [3:0]  qhi_reg   [4];
    logic [3:0]  qhi_next  [4];
    logic [7:0]  mx3_reg;
    logic [3:0]  neg3_reg;

    logic [6:0]  quot_reg  [4];
    logic [6:0]  quot_next [4];
    logic [3:0]  neg4_reg;

    logic signed [7:0] cmd_next [4];

    function automatic logic signed [16:0] quad_cos(input quad_t q, input logic [15:0] c,
                                                    input logic [15:0] sn);
        logic signed [16:0] r;
        case (q)
            QUAD_0:  r = $signed({1'b0, c});
            QUAD_1:  r = -$signed({1'b0, sn});
            QUAD_2:  r = -$signed({1'b0, c});
            QUAD_3:  r = $signed({1'b0, sn});
            default: r = '0;
        endcase
        return r;
    endfunction

    // stage 0: fold to quadrant and multiply by speed
    assign cf      = cls.swap ? sin_q : cos_q;
    assign sf      = cls.swap ? cos_q : sin_q;
    assign cr      = quad_cos(cls.quad, cf, sf);
    assign cl      = quad_cos(quad_t'(2'(cls.quad - 2'd1)), cf, sf);
    assign pr_next = 25'(cls.speed) * 25'(cr);
    assign pl_next = 25'(cls.speed) * 25'(cl);

    // stage 1: diagonals truncated toward zero, wheel mix
    assign tr = pr_reg + (pr_reg < 0 ? 25'sd32767 : 25'sd0);
    assign tl = pl_reg + (pl_reg < 0 ? 25'sd32767 : 25'sd0);
    assign dr = 9'(tr >>> 15);
    assign dl = 9'(tl >>> 15);

    always_comb
    begin
        whl_next[0] = dr + 9'(rot_reg);
        whl_next[1] = dl + 9'(rot_reg);
        whl_next[2] = dl - 9'(rot_reg);
        whl_next[3] = dr - 9'(rot_reg);
    end

    // stage 2: magnitudes, largest magnitude, numerators
    always_comb
    begin
        for (int l = 0; l < 4; l++)
        begin
            mag[l]      = whl_reg[l] < 0 ? 8'(-whl_reg[l]) : 8'(whl_reg[l]);
            num_next[l] = {mag[l], 7'd0} - 15'(mag[l]);
        end
        m01      = mag[0] > mag[1] ? mag[0] : mag[1];
        m23      = mag[2] > mag[3] ? mag[2] : mag[3];
        mall     = m01 > m23 ? m01 : m23;
        mx2_next = mall > 8'd127 ? mall : 8'd127;
    end

    // stage 3: upper quotient bits
    always_comb
    begin
        for (int l = 0; l < 4; l++)
        begin
            rem3_next[l] = num_reg[l];
            qhi_next[l]  = '0;
            for (int i = 3; i >= 0; i--)
            begin
                if (rem3_next[l] >= (15'(mx2_reg) << (i + 3)))
                begin
                    rem3_next[l] = rem3_next[l] - (15'(mx2_reg) << (i + 3));
                    qhi_next[l][i] = 1'b1;
                end
            end
        end
    end

    // stage 4: lower quotient bits
    always_comb
    begin
        logic [14:0] rem;
        for (int l = 0; l < 4; l++)
        begin
            rem          = rem3_reg[l];
            quot_next[l] = {qhi_reg[l], 3'd0};
            for (int i = 2; i >= 0; i--)
            begin
                if (rem >= (15'(mx3_reg) << i))
                begin
                    rem = rem - (15'(mx3_reg) << i);
                    quot_next[l][i] = 1'b1;
                end
            end
        end
    end

    // stage 5: sign restore into output register
    always_comb
    begin
        for (int l = 0; l < 4; l++)
            cmd_next[l] = neg4_reg[l] ? -$signed({1'b0, quot_reg[l]}) : $signed({1'b0, quot_reg[l]});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NST-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pr_reg   <= pr_next;
            pl_reg   <= pl_next;
            rot_reg  <= cls.rot;
            imm_reg  <= {imm_reg[NST-2:0], cls.imm};
            whl_reg  <= whl_next;
            mx2_reg  <= mx2_next;
            num_reg  <= num_next;
            for (int l = 0; l < 4; l++)
                neg2_reg[l] <= whl_reg[l] < 0;
            rem3_reg <= rem3_next;
            qhi_reg  <= qhi_next;
            mx3_reg  <= mx2_reg;
            neg3_reg <= neg2_reg;
            quot_reg <= quot_next;
            neg4_reg <= neg3_reg;
            res.front_right_cmd <= cmd_next[0];
            res.rear_right_cmd  <= cmd_next[1];
            res.front_left_cmd  <= cmd_next[2];
            res.rear_left_cmd   <= cmd_next[3];
        end
    end

    assign res.valid         = vld_reg[NST-1];
    assign res.immediate_out = imm_reg[NST-1];

    a_cmd_range: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (res.front_right_cmd != -8'sd128 && res.rear_right_cmd != -8'sd128 &&
                       res.front_left_cmd != -8'sd128 && res.rear_left_cmd != -8'sd128))
        else $error("wheel command outside -127..127");

    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (en && vld_reg[NST-2]) |=> res.valid)
        else $error("result lost in pipeline advance");

    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("pipeline moved while stalled");

endmodule

`default_nettype wire

>>> design/mecanum_wheel_mixer_core.sv
// mecanum wheel mixer top level: front end, request queue, series unit, mixer
// depends on mwm_pkg, mwm_if, mwm_front, mwm_queue, mwm_series, mwm_mixer
//
//   channel  dir  handshake     payload
//   cmd      in   valid/ready   heading_angle, drive_speed, turn_rate, immediate_flag
//   res      out  valid/ready   four wheel commands, immediate_out
//
// one request per cycle sustained while the result channel does not stall
// back end is the 19-stage Taylor series pipeline plus 6 mixer and divider stages
// back end freezes as a whole while a result waits; the 4-entry queue keeps taking requests until full
// reset clears queue pointers, queue count and stage valid bits only
`default_nettype none

module mecanum_wheel_mixer_core (
    input  wire logic clk,
    input  wire logic rst_n,
    mwm_cmd_if.sink   cmd,
    mwm_whl_if.source res
);
    import mwm_pkg::*;

    cls_t        fr_cls;
    logic        push;
    logic        q_full;
    logic        q_empty;
    logic        pop;
    cls_t        q_cls;
    logic        en;
    logic        ser_valid;
    logic [15:0] cos_q;
    logic [15:0] sin_q;
    cls_t        ser_cls;

    assign en  = !res.valid || res.ready;
    assign pop = en && !q_empty;

    mwm_front u_front (
        .cmd    (cmd),
        .q_full (q_full),
        .push   (push),
        .cls    (fr_cls)
    );

    mwm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (fr_cls),
        .pop       (pop),
        .full      (q_full),
        .empty     (q_empty),
        .pop_data  (q_cls)
    );

    mwm_series u_series (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (!q_empty),
        .in_cls    (q_cls),
        .out_valid (ser_valid),
        .cos_q     (cos_q),
        .sin_q     (sin_q),
        .out_cls   (ser_cls)
    );

    mwm_mixer u_mixer (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (ser_valid),
        .cos_q    (cos_q),
        .sin_q    (sin_q),
        .cls      (ser_cls),
        .res      (res)
    );

endmodule

`default_nettype wire
